// ===== src/spq_pkg.sv =====
// spq_pkg: shared types and constants for the sorted priority queue
// no dependencies; imported by spq_ctrl, spq_datapath, sorted_priority_queue and the sim checker and test
package spq_pkg;

    localparam int DEPTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 6;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    typedef struct packed {
        logic        func;
        logic [15:0] new_id;
        logic [7:0]  new_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      head_id;
        logic [7:0]       head_priority;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic remove;
        logic capture;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

// ===== src/spq_ctrl.sv =====
// spq_ctrl: request controller, decodes requests into datapath commands
// depends on spq_pkg
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                func,
    input  spq_pkg::dp_status_t dp_status,
    output spq_pkg::ctl_cmd_t   cmd,
    output logic                done,
    output logic [1:0]          status
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REPORT = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;

    always_comb
    begin
        cmd         = '0;
        status_next = status_reg;
        state_next  = accept ? S_REPORT : S_IDLE;
        if (accept)
        begin
            cmd.capture = 1'b1;
            unique case (func)
                FUNC_ENQ:
                begin
                    cmd.insert  = !dp_status.full;
                    status_next = dp_status.full ? ST_OVERFLOW : ST_OK;
                end
                default:
                begin
                    cmd.remove  = !dp_status.empty;
                    status_next = dp_status.empty ? ST_EMPTY : ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign done   = (state_reg == S_REPORT);
    assign status = status_reg;

endmodule

// ===== src/spq_datapath.sv =====
// spq_datapath: sorted cell array, entry count and result registers
// depends on spq_pkg
module spq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::req_t       req,
    input  spq_pkg::ctl_cmd_t   cmd,
    output spq_pkg::dp_status_t dp_status,
    output logic [15:0]         head_id,
    output logic [7:0]          head_priority,
    output logic [spq_pkg::OCC_W-1:0] occupancy
);
    import spq_pkg::*;

    logic [15:0]      id_reg  [DEPTH];
    logic [7:0]       pri_reg [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      head_id_reg;
    logic [7:0]       head_pri_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [DEPTH-1:0] keep;

    // cell stays put when it is occupied and ranks at or above the new entry
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = (CNT_W'(i) < count_reg) && (pri_reg[i] >= req.new_priority);
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (cmd.insert && !keep[g])
            begin
                if (g == 0)
                begin
                    id_reg[g]  <= req.new_id;
                    pri_reg[g] <= req.new_priority;
                end
                else if (keep[(g == 0) ? 0 : g-1])
                begin
                    id_reg[g]  <= req.new_id;
                    pri_reg[g] <= req.new_priority;
                end
                else
                begin
                    id_reg[g]  <= id_reg[(g == 0) ? 0 : g-1];
                    pri_reg[g] <= pri_reg[(g == 0) ? 0 : g-1];
                end
            end
            else if (cmd.remove && (g < DEPTH-1))
            begin
                id_reg[g]  <= id_reg[(g < DEPTH-1) ? g+1 : g];
                pri_reg[g] <= pri_reg[(g < DEPTH-1) ? g+1 : g];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            head_id_reg  <= cmd.remove ? id_reg[0]  : 16'd0;
            head_pri_reg <= cmd.remove ? pri_reg[0] : 8'd0;
            occ_reg      <= OCC_W'(count_next);
        end
    end

    assign dp_status.full  = (count_reg >= CNT_W'(DEPTH));
    assign dp_status.empty = (count_reg == '0);
    assign head_id         = head_id_reg;
    assign head_priority   = head_pri_reg;
    assign occupancy       = occ_reg;

endmodule

// ===== src/sorted_priority_queue.sv =====
// sorted_priority_queue: top level, sorted-array priority queue of DEPTH entries
// result strobe comes in the cycle after the accepting edge; one request per cycle
// throughput set by the cell array, which compares and shifts all cells at once
// busy stays low, the receiver cannot stall and takes every done strobe
// reset: asynchronous, clears entry count and controller state; cell contents stay undefined
module sorted_priority_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::req_t req,
    output logic          done,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t dp_status;
    logic       accept;
    logic [1:0] status;

    // each request's queue update and result are registered at the edge that takes it
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // controller: decodes func against full and empty flags
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (req.func),
        .dp_status (dp_status),
        .cmd       (cmd),
        .done      (done),
        .status    (status)
    );

    // datapath: sorted cells, count, registered head and occupancy
    spq_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .head_id       (rsp.head_id),
        .head_priority (rsp.head_priority),
        .occupancy     (rsp.occupancy)
    );

    assign rsp.status = status;

    // each accepted request yields a strobe on the next cycle
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result strobe");

    // refused requests never return an entry
    a_no_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != ST_OK) |-> (rsp.head_id == 16'd0) && (rsp.head_priority == 8'd0))
        else $error("head returned on refused request");

    // overflow only when full
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == ST_OVERFLOW) |-> (rsp.occupancy == OCC_FULL))
        else $error("overflow below full");

    // empty flag only when nothing held
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0))
        else $error("empty flag with entries held");

endmodule

// ===== sim/sorted_priority_queue_checker.sv =====
// sorted_priority_queue_checker: watches the request and result channels of the queue,
// keeps its own sorted copy of the entries and compares every result field by field
// depends on spq_pkg for the request and result types and the status codes
module sorted_priority_queue_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  spq_pkg::req_t req,
    input  logic          done,
    input  spq_pkg::rsp_t rsp,
    output int            mismatches,
    output int            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // shadow copy of the queue, slot 0 is the head
    logic [15:0] shadow_id [DEPTH];
    logic [7:0]  shadow_prio [DEPTH];
    int          shadow_count;

    rsp_t        awaited_results[$];
    rsp_t        oldest;

    // apply one request to the shadow queue and return the result it should give
    function automatic rsp_t serve_request(input req_t r);
        rsp_t res;
        int   pos;
        int   k;
        res = '0;
        res.status = ST_OK;
        if (r.func == FUNC_ENQ)
        begin
            if (shadow_count >= DEPTH)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                // new entry goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= r.new_priority)
                    pos++;
                for (k = shadow_count; k > pos; k--)
                begin
                    shadow_id[k]   = shadow_id[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_id[pos]   = r.new_id;
                shadow_prio[pos] = r.new_priority;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            res.head_id       = shadow_id[0];
            res.head_priority = shadow_prio[0];
            for (k = 1; k < shadow_count; k++)
            begin
                shadow_id[k-1]   = shadow_id[k];
                shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_count--;
        end
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    initial
    begin
        mismatches    = 0;
        pending_count = 0;
        shadow_count  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            awaited_results.delete();
            pending_count = 0;
        end
        else
        begin
            // results first, so a request taken at this edge never matches its own strobe
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding: expected none, actual %h",
                             $time, rsp);
                    mismatches++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (rsp.status !== oldest.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, oldest.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.head_id !== oldest.head_id)
                    begin
                        $display("%0t: head_id mismatch: expected %h, actual %h",
                                 $time, oldest.head_id, rsp.head_id);
                        mismatches++;
                    end
                    if (rsp.head_priority !== oldest.head_priority)
                    begin
                        $display("%0t: head_priority mismatch: expected %h, actual %h",
                                 $time, oldest.head_priority, rsp.head_priority);
                        mismatches++;
                    end
                    if (rsp.occupancy !== oldest.occupancy)
                    begin
                        $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                                 $time, oldest.occupancy, rsp.occupancy);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                awaited_results.push_back(serve_request(req));
            pending_count = awaited_results.size();
        end
    end

endmodule

// ===== sim/sorted_priority_queue_test.sv =====
// sorted_priority_queue_test: stimulus and verdict for the sorted priority queue
// depends on spq_pkg, sorted_priority_queue and sorted_priority_queue_checker
// directed corner requests first, then random fill, drain and mixed stretches
module sorted_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int TOTAL_ITEMS  = 1150;
    // no idle gaps over the final stretch of requests
    localparam int QUIET_TAIL   = 150;
    // many times over the worst case for TOTAL_ITEMS requests, so only a hang reaches it
    localparam int CYCLE_LIMIT  = 200000;
    // result comes in the cycle after acceptance; the spare wait catches stray strobes
    localparam int DRAIN_CYCLES = 8;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    req_t   req;
    logic   done;
    rsp_t   rsp;
    int     mismatches;
    int     pending_count;
    int     issued;
    longint cycles = 0;

    sorted_priority_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // checker sits beside the block, predicts every result and counts mismatches
    sorted_priority_queue_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .done          (done),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // drive one request at the falling edge and hold it until the block takes it
    task automatic issue(input logic f, input logic [15:0] id, input logic [7:0] pri);
        req_t r;
        r.func         = f;
        r.new_id       = id;
        r.new_priority = pri;
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        issued++;
    endtask

    // idle gap with start low, its length given by n
    task automatic rest(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    initial
    begin
        logic        f;
        logic [15:0] id;
        logic [7:0]  pri;
        int          mode;
        int          seg;
        bit          quiet;

        start  = 1'b0;
        req    = '0;
        rst_n  = 1'b0;
        issued = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // dequeue on an empty queue right after reset
        issue(FUNC_DEQ, 16'h0000, 8'h00);
        // field extremes: lowest and highest id and priority
        issue(FUNC_ENQ, 16'h0000, 8'h00);
        issue(FUNC_ENQ, 16'hFFFF, 8'hFF);
        // run of equal priorities, must leave in arrival order
        issue(FUNC_ENQ, 16'h1234, 8'h80);
        issue(FUNC_ENQ, 16'h1235, 8'h80);
        issue(FUNC_ENQ, 16'hA5A5, 8'h80);
        // ties at the bottom and at the top of the priority range
        issue(FUNC_ENQ, 16'h5A5A, 8'h00);
        issue(FUNC_ENQ, 16'h0001, 8'hFF);
        // new entry that lands at the tail
        issue(FUNC_ENQ, 16'h7FFF, 8'h00);
        // drain everything, then one more dequeue on empty
        repeat (8) issue(FUNC_DEQ, 16'hFFFF, 8'hFF);
        issue(FUNC_DEQ, 16'h0000, 8'h00);

        // random stretches: fill mode pushes the queue to full and into overflow,
        // drain mode empties it and keeps dequeuing, mixed mode churns the middle
        while (issued < TOTAL_ITEMS)
        begin
            mode  = $urandom_range(0, 2);
            seg   = $urandom_range(10, 60);
            quiet = ($urandom_range(0, 3) == 0);
            repeat (seg)
            begin
                if (issued >= TOTAL_ITEMS)
                    break;
                case (mode)
                    0:       f = ($urandom_range(0, 9) != 0) ? FUNC_ENQ : FUNC_DEQ;
                    1:       f = ($urandom_range(0, 9) == 0) ? FUNC_ENQ : FUNC_DEQ;
                    default: f = ($urandom_range(0, 1) != 0) ? FUNC_ENQ : FUNC_DEQ;
                endcase
                // narrow priority ranges now and then so ties are common
                case ($urandom_range(0, 3))
                    0, 1:    pri = 8'($urandom_range(0, 255));
                    2:       pri = 8'($urandom_range(0, 3));
                    default: pri = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                endcase
                id = 16'($urandom_range(0, 65535));
                issue(f, id, pri);
                // short random gaps, none in quiet stretches or over the tail
                if (!quiet && issued < TOTAL_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
                    rest($urandom_range(1, 4));
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // wait for every predicted result, then wait out DRAIN_CYCLES for stray strobes
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
